// ===== sv/skvt_pkg.sv =====
// Shared types and request codes for the sorted key/value table.
// Used by skvt_cell and sorted_key_value_table; depends on nothing else.
`default_nettype none

package skvt_pkg;

  localparam int unsigned KeyW   = 32;
  localparam int unsigned ValW   = 32;
  localparam int unsigned ReqW   = 2;
  localparam int unsigned CountW = 5;

  // Request kinds carried on the slave tuser
  typedef enum logic [ReqW-1:0] {
    REQ_ADD    = 2'd0,
    REQ_SEARCH = 2'd1,
    REQ_REMOVE = 2'd2
  } skvt_req_e;

  // One stored entry as handed between neighbouring cells
  typedef struct packed {
    logic            valid;
    logic [KeyW-1:0] key;
    logic [ValW-1:0] value;
  } skvt_entry_t;

  // Request payload broadcast to every cell
  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [ValW-1:0] value;
    logic            descending;
  } skvt_cmd_t;

  // Update strobes decided at the top level from the cells' hit flags
  typedef struct packed {
    logic do_insert;
    logic do_remove;
    logic do_update;
  } skvt_op_t;

endpackage : skvt_pkg

`default_nettype wire

// ===== sv/skvt_cell.sv =====
// One slot of the sorted table: holds an entry, compares it with the request
// and shifts to or from its neighbours. Depends on skvt_pkg.
`default_nettype none

module skvt_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  skvt_pkg::skvt_cmd_t   cmd_i,
  input  skvt_pkg::skvt_op_t    op_i,
  input  skvt_pkg::skvt_entry_t prev_i,   // entry of the cell below
  input  skvt_pkg::skvt_entry_t next_i,   // entry of the cell above
  input  logic               ins_i,       // insertion point lies below
  input  logic               rm_i,        // removed entry lies below
  output logic               ins_o,
  output logic               rm_o,
  output logic               hit_o,
  output logic [skvt_pkg::ValW-1:0] hit_value_o,
  output skvt_pkg::skvt_entry_t entry_o
);
  import skvt_pkg::*;

  logic            valid_q, valid_d;
  logic [KeyW-1:0] key_q, key_d;
  logic [ValW-1:0] value_q, value_d;
  logic            precedes;
  logic            slot_end;
  logic            place;

  // Local compare against the request key
  always_comb begin
    hit_o    = valid_q && (key_q == cmd_i.key);
    precedes = valid_q && (cmd_i.descending ? ($signed(key_q) < $signed(cmd_i.key))
                                            : ($signed(cmd_i.key) < $signed(key_q)));
    slot_end = !valid_q && prev_i.valid;
    ins_o    = ins_i || precedes || slot_end;
    place    = ins_o && !ins_i;
    rm_o     = rm_i || hit_o;
    hit_value_o = hit_o ? value_q : '0;
  end

  // Next contents: shift up or take the request entry on insert, shift down on remove, new value on update
  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    value_d = value_q;
    if (op_i.do_insert) begin
      if (ins_i) begin
        valid_d = prev_i.valid;
        key_d   = prev_i.key;
        value_d = prev_i.value;
      end else if (place) begin
        valid_d = 1'b1;
        key_d   = cmd_i.key;
        value_d = cmd_i.value;
      end
    end
    if (op_i.do_remove && rm_o) begin
      valid_d = next_i.valid;
      key_d   = next_i.key;
      value_d = next_i.value;
    end
    if (op_i.do_update && hit_o) begin
      value_d = cmd_i.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    value_q <= value_d;
  end

  assign entry_o = '{valid: valid_q, key: key_q, value: value_q};

endmodule : skvt_cell

`default_nettype wire

// ===== sv/sorted_key_value_table.sv =====
// Top level of the sorted key/value table: stream ports, request sequencing
// and the row of skvt_cell slots. Depends on skvt_pkg and skvt_cell.
`default_nettype none

// Holds up to DEPTH key/value pairs in a row of cells kept ordered by key,
// ascending or descending as set by cfg_wdata_i. The request is registered on
// acceptance; then in the next cycle every cell compares its key with the
// request at once, and at the end of that cycle the row is shifted up (insert)
// or down (remove) or the matching value is updated (add of a stored key). No
// new request is accepted while one is in flight. s_axis_tready_o is high
// while no request is in flight and the result register is empty or being
// taken. Every request gives one result. An add of a new key to a full table
// leaves the table unchanged and returns status 1. Changing the order while
// entries are stored does not re-sort them; it only steers later inserts.
module sorted_key_value_table #(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,       // order_descending
  // request stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,    // [31:0] key, [63:32] new_value
  input  logic [1:0]  s_axis_tuser_i,    // [1:0] req_type
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,    // [31:0] result_value, [36:32] entry_count
  output logic [1:0]  m_axis_tuser_o     // [0] found, [1] status
);
  import skvt_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic            state_q, state_d;
  logic            order_q;
  logic [ReqW-1:0] req_q;
  logic [KeyW-1:0] key_q;
  logic [ValW-1:0] val_q;
  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q;
  logic [ValW-1:0] out_value_q;
  logic            out_found_q;
  logic            out_status_q;
  logic [CountW-1:0] out_count_q;

  logic            in_fire;
  logic            exec;
  skvt_cmd_t       cmd;
  skvt_op_t        op;
  skvt_entry_t     entry [DEPTH];
  logic [DEPTH:0]  ins_chain;
  logic [DEPTH:0]  rm_chain;
  logic [DEPTH-1:0] hit_vec;
  logic [DEPTH-1:0] valid_vec;
  logic [ValW-1:0] hit_value [DEPTH];
  logic [ValW-1:0] hit_value_or;
  logic            any_hit;
  logic            full;
  logic            is_add, is_search, is_remove;
  logic            found;
  logic            status;
  logic [CntW+CountW-1:0] count_ext;

  // Handshake and sequencing
  assign exec            = (state_q == ST_EXEC);
  assign s_axis_tready_o = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready_i);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_fire) state_d = ST_EXEC;
      ST_EXEC: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Broadcast request
  assign cmd = '{key: key_q, value: val_q, descending: order_q};

  // Cell row
  assign ins_chain[0] = 1'b0;
  assign rm_chain[0]  = 1'b0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    skvt_entry_t prev_e, next_e;
    if (g == 0) begin : g_first
      assign prev_e = '{valid: 1'b1, key: '0, value: '0};
    end else begin : g_mid
      assign prev_e = entry[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign next_e = '0;
    end else begin : g_inner
      assign next_e = entry[g+1];
    end

    skvt_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .op_i        (op),
      .prev_i      (prev_e),
      .next_i      (next_e),
      .ins_i       (ins_chain[g]),
      .rm_i        (rm_chain[g]),
      .ins_o       (ins_chain[g+1]),
      .rm_o        (rm_chain[g+1]),
      .hit_o       (hit_vec[g]),
      .hit_value_o (hit_value[g]),
      .entry_o     (entry[g])
    );

    assign valid_vec[g] = entry[g].valid;
  end

  // Gather the matching value
  always_comb begin
    hit_value_or = '0;
    for (int i = 0; i < DEPTH; i++) begin
      hit_value_or = hit_value_or | hit_value[i];
    end
  end

  // Decide the operation
  assign any_hit   = |hit_vec;
  assign full      = valid_vec[DEPTH-1];
  assign is_add    = (req_q == REQ_ADD);
  assign is_search = (req_q == REQ_SEARCH);
  assign is_remove = (req_q == REQ_REMOVE);

  always_comb begin
    op.do_update = exec && is_add && any_hit;
    op.do_insert = exec && is_add && !any_hit && !full;
    op.do_remove = exec && is_remove && any_hit;
    found        = any_hit && (is_add || is_search || is_remove);
    status       = is_add && !any_hit && full;
    count_d      = count_q;
    if (op.do_insert) count_d = count_q + CntW'(1);
    else if (op.do_remove) count_d = count_q - CntW'(1);
    count_ext    = {{CountW{1'b0}}, count_d};
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      order_q     <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (cfg_we_i) order_q <= cfg_wdata_i;
      if (exec) out_valid_q <= 1'b1;
      else if (m_axis_tready_i) out_valid_q <= 1'b0;
    end
  end

  // Request and result payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q <= s_axis_tuser_i;
      key_q <= s_axis_tdata_i[31:0];
      val_q <= s_axis_tdata_i[63:32];
    end
    if (exec) begin
      out_value_q  <= found ? hit_value_or : '0;
      out_found_q  <= found;
      out_status_q <= status;
      out_count_q  <= count_ext[CountW-1:0];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_count_q, out_value_q};
  assign m_axis_tuser_o  = {out_status_q, out_found_q};

  // Checks
  a_one_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(hit_vec))
    else $error("key stored in more than one cell");

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == CntW'($countones(valid_vec)))
    else $error("entry count disagrees with valid cells");

  a_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(valid_vec + DEPTH'(1)))
    else $error("valid cells not packed from the bottom");

  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> ##1 out_valid_q)
    else $error("accepted transaction gave no result");

endmodule : sorted_key_value_table

`default_nettype wire

// ===== tb/sorted_key_value_table_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for sorted_key_value_table: directed and random add,
// search and remove traffic checked against a behavioural table model.
// Depends on skvt_pkg and the sorted_key_value_table RTL.

module sorted_key_value_table_test;
  import skvt_pkg::*;

  localparam int unsigned TABLE_DEPTH  = 16;
  localparam int unsigned PHASE_ITEMS  = 230;
  localparam logic [1:0]  REQ_UNUSED   = 2'd3;
  localparam logic [31:0] KEY_MIN      = 32'h8000_0000;
  localparam logic [31:0] KEY_MAX      = 32'h7FFF_FFFF;

  // Fields of one result as the table returns it
  typedef struct packed {
    logic [31:0] value;
    logic        found;
    logic        status;
    logic [4:0]  count;
  } table_result_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        cfg_we_i        = 1'b0;
  logic        cfg_wdata_i     = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [63:0] s_axis_tdata_i  = '0;   // [31:0] key, [63:32] new_value
  logic [1:0]  s_axis_tuser_i  = '0;   // [1:0] req_type
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [39:0] m_axis_tdata_o;         // [31:0] result_value, [36:32] entry_count
  logic [1:0]  m_axis_tuser_o;         // [0] found, [1] status

  // Table model state
  logic signed [31:0] stored_keys[$];
  logic signed [31:0] stored_vals[$];
  logic               order_desc = 1'b0;

  table_result_t      pending_results[$];
  int unsigned        mismatch_count = 0;
  int unsigned        send_idle_pct  = 0;
  int unsigned        recv_stall_pct = 0;
  logic [31:0]        key_pool[20];

  sorted_key_value_table #(
    .DEPTH(TABLE_DEPTH)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always #10 clk_i = ~clk_i;

  // Overall time limit
  initial begin
    #20_000_000;
    $display("sorted_key_value_table_test NOT OK");
    $finish;
  end

  // Applies one request to the model table and returns the expected result
  function automatic table_result_t apply_request(input logic [1:0] req,
                                                  input logic signed [31:0] key,
                                                  input logic signed [31:0] val);
    table_result_t res;
    int            hit;
    int            slot;
    res = '0;
    hit = -1;
    foreach (stored_keys[i]) begin
      if (stored_keys[i] == key && hit < 0) hit = i;
    end
    case (req)
      REQ_ADD: begin
        if (hit >= 0) begin
          res.value = stored_vals[hit];
          res.found = 1'b1;
          stored_vals[hit] = val;
        end else if (stored_keys.size() >= TABLE_DEPTH) begin
          res.status = 1'b1;
        end else begin
          // first entry that the new key strictly precedes, else the end
          slot = stored_keys.size();
          for (int i = stored_keys.size() - 1; i >= 0; i--) begin
            if (order_desc ? (key > stored_keys[i]) : (key < stored_keys[i])) slot = i;
          end
          stored_keys.insert(slot, key);
          stored_vals.insert(slot, val);
        end
      end
      REQ_SEARCH: begin
        if (hit >= 0) begin
          res.value = stored_vals[hit];
          res.found = 1'b1;
        end
      end
      REQ_REMOVE: begin
        if (hit >= 0) begin
          res.value = stored_vals[hit];
          res.found = 1'b1;
          stored_keys.delete(hit);
          stored_vals.delete(hit);
        end
      end
      default: ;
    endcase
    res.count = 5'(stored_keys.size());
    return res;
  endfunction

  // Sends one request, idling first at the current sender rate
  task automatic send_request(input logic [1:0] req, input logic [31:0] key,
                              input logic [31:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {val, key};
    s_axis_tuser_i  <= req;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    pending_results.push_back(apply_request(req, key, val));
  endtask

  // Holds the sender off until every outstanding result has come back
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_order(input logic desc);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= desc;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    order_desc = desc;
  endtask

  // Receiver back-pressure
  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  // Result checker: each transaction against the oldest expectation
  always @(posedge clk_i) begin
    table_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding");
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("result_value", want.value, m_axis_tdata_o[31:0]);
        check_field("found", 32'(want.found), 32'(m_axis_tuser_o[0]));
        check_field("status", 32'(want.status), 32'(m_axis_tuser_o[1]));
        check_field("entry_count", 32'(want.count), 32'(m_axis_tdata_o[36:32]));
      end
    end
  end

  // Lookups on an empty table and the unused request code
  task automatic test_empty_table();
    send_request(REQ_SEARCH, 32'd0, 32'hFFFF_FFFF);
    send_request(REQ_REMOVE, KEY_MIN, 32'd0);
    send_request(REQ_UNUSED, 32'd0, 32'h1234_5678);
  endtask

  // Extreme keys and values, update of a stored key, remove hit and miss
  task automatic test_extremes_and_update();
    send_request(REQ_ADD, KEY_MIN, KEY_MAX);
    send_request(REQ_ADD, KEY_MAX, KEY_MIN);
    send_request(REQ_ADD, 32'd0, 32'd0);
    send_request(REQ_ADD, 32'hFFFF_FFFF, 32'h5555_5555);
    send_request(REQ_ADD, 32'hFFFF_FFFF, 32'hAAAA_AAAA);
    send_request(REQ_SEARCH, KEY_MAX, 32'd0);
    send_request(REQ_REMOVE, 32'd0, 32'd0);
    send_request(REQ_REMOVE, 32'd0, 32'd0);
    send_request(REQ_UNUSED, KEY_MIN, 32'd0);
  endtask

  // Fill to capacity, reject a new key, update a stored one
  task automatic test_full_table();
    int k;
    k = 1;
    while (stored_keys.size() < TABLE_DEPTH) begin
      send_request(REQ_ADD, 32'(k * 7), $urandom);
      k++;
    end
    send_request(REQ_ADD, 32'd1000, 32'hDEAD_BEEF);
    send_request(REQ_ADD, 32'd7, 32'hCAFE_F00D);
    send_request(REQ_SEARCH, 32'd1000, 32'd0);
  endtask

  // Order flipped with entries stored: no re-sort, later adds steered only
  task automatic test_order_switch();
    set_order(1'b1);
    send_request(REQ_REMOVE, KEY_MAX, 32'd0);
    send_request(REQ_REMOVE, 32'd14, 32'd0);
    send_request(REQ_ADD, 32'd10, 32'h0BAD_F00D);
    send_request(REQ_ADD, 32'd500, 32'h0000_0001);
    send_request(REQ_SEARCH, 32'd10, 32'd0);
  endtask

  // Random traffic over a small key pool so that hits, full and empty occur
  task automatic test_random_traffic();
    int unsigned add_pct;
    int unsigned pick;
    logic [31:0] key;
    logic [1:0]  req;
    for (int phase = 0; phase < 8; phase++) begin
      set_order(phase[0] ^ phase[2]);
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      foreach (key_pool[i]) key_pool[i] = $urandom;
      key_pool[0] = KEY_MIN;
      key_pool[1] = KEY_MAX;
      add_pct = $urandom_range(35, 60);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        key = ($urandom_range(99) < 85) ? key_pool[$urandom_range(19)] : $urandom;
        pick = $urandom_range(99);
        if (pick < add_pct) req = REQ_ADD;
        else if (pick < add_pct + (100 - add_pct) / 2) req = REQ_SEARCH;
        else if (pick < 98) req = REQ_REMOVE;
        else req = REQ_UNUSED;
        send_request(req, key, $urandom);
        // one mid-phase pause until the table has answered everything
        if (n == PHASE_ITEMS / 2 && phase == 3) drain_results();
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_table();
    test_extremes_and_update();
    test_full_table();
    test_order_switch();
    test_random_traffic();
    set_order(1'b0);
    drain_results();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("sorted_key_value_table_test OK");
    end else begin
      $display("sorted_key_value_table_test NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/skvt_pkg.sv
sv/skvt_cell.sv
sv/sorted_key_value_table.sv
tb/sorted_key_value_table_test.sv
